// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers for the byte FIFO core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define FCBF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked at every rising clock edge, reset included.
`define FCBF_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== hw/rtl/fcbf_pkg.sv =====
package fcbf_pkg;

  localparam int FUNC_W = 3;
  localparam int BYTE_W = 8;
  localparam int LEN_W  = 7;
  localparam int STAT_W = 2;
  localparam int CNT_W  = 11;
  localparam int TOT_W  = 48;

  localparam logic [FUNC_W-1:0] FUNC_WRITE = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_PEEK  = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_POP   = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_READ  = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_END   = 3'd4;

  localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_RANGE = 2'd2;

  localparam logic [CNT_W-1:0] CAP_RESET = 11'd1024;
  localparam logic [CNT_W-1:0] CNT_MAX   = 11'd2047;
  localparam logic [TOT_W-1:0] TOT_MAX   = 48'hFFFF_FFFF_FFFF;

endpackage

// ===== hw/rtl/flow_controlled_byte_fifo_core.sv =====
// Byte FIFO with a programmable capacity, held in a single-port-read memory of DEPTH bytes.
// Each transfer on the input channel carries one operation. Write, pop, end input, unused
// codes and any operation that fails its check give one result. A peek or read of N bytes
// gives N results (one if N is zero); the sequencer fetches one byte from the memory read
// port, then loads it into the output register when the output side does not stall, and it
// takes no new item until it has loaded the last byte of the item.
// The occupancy, space, flag and total outputs already show the state after the whole item.
// The capacity register may be written only while the block is idle. No clearing pass is
// needed after reset.

`include "assert_macros.svh"

module flow_controlled_byte_fifo_core #(
  parameter int DEPTH   = 1024,
  parameter int MAX_LEN = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [fcbf_pkg::CNT_W-1:0]     cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [fcbf_pkg::FUNC_W-1:0]    func_i,
  input  logic [fcbf_pkg::BYTE_W-1:0]    data_in_i,
  input  logic [fcbf_pkg::LEN_W-1:0]     length_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [fcbf_pkg::BYTE_W-1:0]    data_out_o,
  output logic                           last_o,
  output logic [fcbf_pkg::STAT_W-1:0]    status_o,
  output logic [fcbf_pkg::CNT_W-1:0]     occupancy_o,
  output logic [fcbf_pkg::CNT_W-1:0]     space_left_o,
  output logic                           ended_o,
  output logic                           at_eof_o,
  output logic [fcbf_pkg::TOT_W-1:0]     total_written_o,
  output logic [fcbf_pkg::TOT_W-1:0]     total_read_o
);

  localparam int CNT_W = fcbf_pkg::CNT_W;
  localparam int TOT_W = fcbf_pkg::TOT_W;
  localparam int TS    = TOT_W + 1;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SW    = ((AW > CNT_W) ? AW : CNT_W) + 1;
  localparam int LW    = $clog2(MAX_LEN + 1);

  localparam logic [CNT_W-1:0] DEPTH_CAP =
    (DEPTH > 2047) ? fcbf_pkg::CNT_MAX : CNT_W'(DEPTH);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_FETCH = 2'd1;
  localparam logic [1:0] ST_EMIT  = 2'd2;

  function automatic logic [AW-1:0] wrap_add(logic [AW-1:0] base, logic [CNT_W-1:0] off);
    logic [SW-1:0] s;
    s = SW'(base) + SW'(off);
    if (s >= SW'(DEPTH)) begin
      s = s - SW'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  logic [fcbf_pkg::BYTE_W-1:0] mem [DEPTH];

  logic [1:0]                  state_q, state_d;
  logic [CNT_W-1:0]            cap_q;
  logic [AW-1:0]               head_q, head_d;
  logic [CNT_W-1:0]            fill_q, fill_d;
  logic [TOT_W-1:0]            total_wr_q, total_wr_d;
  logic [TOT_W-1:0]            total_rd_q, total_rd_d;
  logic                        done_q, done_d;
  logic [AW-1:0]               rd_ptr_q, rd_ptr_d;
  logic [LW-1:0]               remain_q, remain_d;
  logic [fcbf_pkg::BYTE_W-1:0] rdata_q;
  logic                        out_valid_q, out_valid_d;
  logic [fcbf_pkg::BYTE_W-1:0] out_data_q, out_data_d;
  logic                        out_last_q, out_last_d;
  logic [fcbf_pkg::STAT_W-1:0] out_status_q, out_status_d;

  logic             out_free;
  logic             in_accept;
  logic [CNT_W-1:0] eff_cap;
  logic [CNT_W-1:0] len_zx;
  logic             range_err;
  logic [TS-1:0]    rd_sum;
  logic             mem_we;
  logic [AW-1:0]    wr_addr;

  assign eff_cap   = (cap_q > DEPTH_CAP) ? DEPTH_CAP : cap_q;
  assign out_free  = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE) || !out_free;
  assign in_accept = in_valid_i && !in_stall_o;
  assign len_zx    = CNT_W'(length_i);
  assign range_err = (len_zx > fill_q) || (length_i > fcbf_pkg::LEN_W'(MAX_LEN));
  assign rd_sum    = TS'(total_rd_q) + TS'(length_i);
  assign wr_addr   = wrap_add(head_q, fill_q);

  always_comb begin
    state_d      = state_q;
    head_d       = head_q;
    fill_d       = fill_q;
    total_wr_d   = total_wr_q;
    total_rd_d   = total_rd_q;
    done_d       = done_q;
    rd_ptr_d     = rd_ptr_q;
    remain_d     = remain_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_data_d   = out_data_q;
    out_last_d   = out_last_q;
    out_status_d = out_status_q;
    mem_we       = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          out_valid_d  = 1'b1;
          out_data_d   = '0;
          out_last_d   = 1'b1;
          out_status_d = fcbf_pkg::STATUS_OK;
          unique case (func_i) inside
            fcbf_pkg::FUNC_WRITE: begin
              if (fill_q >= eff_cap) begin
                out_status_d = fcbf_pkg::STATUS_FULL;
              end else begin
                mem_we     = 1'b1;
                fill_d     = fill_q + CNT_W'(1);
                total_wr_d = (total_wr_q == fcbf_pkg::TOT_MAX) ? total_wr_q
                                                                : total_wr_q + TOT_W'(1);
              end
            end
            fcbf_pkg::FUNC_END: begin
              done_d = 1'b1;
            end
            fcbf_pkg::FUNC_PEEK, fcbf_pkg::FUNC_POP, fcbf_pkg::FUNC_READ: begin
              if (range_err) begin
                out_status_d = fcbf_pkg::STATUS_RANGE;
              end else begin
                if (func_i != fcbf_pkg::FUNC_PEEK) begin
                  head_d     = wrap_add(head_q, len_zx);
                  fill_d     = fill_q - len_zx;
                  total_rd_d = rd_sum[TOT_W] ? fcbf_pkg::TOT_MAX : rd_sum[TOT_W-1:0];
                end
                if (func_i != fcbf_pkg::FUNC_POP && length_i != '0) begin
                  out_valid_d = 1'b0;
                  rd_ptr_d    = head_q;
                  remain_d    = LW'(length_i);
                  state_d     = ST_FETCH;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_FETCH: begin
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_data_d   = rdata_q;
          out_last_d   = (remain_q == LW'(1));
          out_status_d = fcbf_pkg::STATUS_OK;
          rd_ptr_d     = wrap_add(rd_ptr_q, CNT_W'(1));
          remain_d     = remain_q - LW'(1);
          state_d      = (remain_q == LW'(1)) ? ST_IDLE : ST_FETCH;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wr_addr] <= data_in_i;
    end
    rdata_q <= mem[rd_ptr_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cap_q       <= fcbf_pkg::CAP_RESET;
      head_q      <= '0;
      fill_q      <= '0;
      total_wr_q  <= '0;
      total_rd_q  <= '0;
      done_q      <= 1'b0;
      remain_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      head_q      <= head_d;
      fill_q      <= fill_d;
      total_wr_q  <= total_wr_d;
      total_rd_q  <= total_rd_d;
      done_q      <= done_d;
      remain_q    <= remain_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_ptr_q     <= rd_ptr_d;
    out_data_q   <= out_data_d;
    out_last_q   <= out_last_d;
    out_status_q <= out_status_d;
  end

  assign out_valid_o     = out_valid_q;
  assign data_out_o      = out_data_q;
  assign last_o          = out_last_q;
  assign status_o        = out_status_q;
  assign occupancy_o     = fill_q;
  assign space_left_o    = (eff_cap > fill_q) ? (eff_cap - fill_q) : '0;
  assign ended_o         = done_q;
  assign at_eof_o        = done_q && (fill_q == '0);
  assign total_written_o = total_wr_q;
  assign total_read_o    = total_rd_q;

  `FCBF_ASSERT_ALWAYS(a_fill_in_bounds, fill_q <= DEPTH_CAP,
                      "Fill count exceeds the memory depth.")
  `FCBF_ASSERT(a_burst_has_bytes, (state_q != ST_IDLE) |-> (remain_q != '0),
               "Burst without bytes left.")
  `FCBF_ASSERT(a_state_frozen_in_burst,
               (state_q != ST_IDLE) |=> ($stable(fill_q) && $stable(total_rd_q) && $stable(head_q)),
               "FIFO state changed during a burst.")

endmodule

// ===== tb/flow_controlled_byte_fifo_core_tb.sv =====
`timescale 1ns / 100ps

module flow_controlled_byte_fifo_core_tb;

  localparam int FIFO_DEPTH   = 1024;
  localparam int FIFO_MAX_LEN = 64;
  localparam logic [fcbf_pkg::FUNC_W-1:0] FUNC_SPARE_FIRST = 3'd5;
  localparam int RANDOM_ITEMS = 340;
  localparam int EXP_DEPTH    = 256;

  typedef struct {
    logic [fcbf_pkg::BYTE_W-1:0] data;
    logic                        last;
    logic [fcbf_pkg::STAT_W-1:0] status;
    logic [fcbf_pkg::CNT_W-1:0]  occupancy;
    logic [fcbf_pkg::CNT_W-1:0]  space_left;
    logic                        ended;
    logic                        at_eof;
    logic [fcbf_pkg::TOT_W-1:0]  total_written;
    logic [fcbf_pkg::TOT_W-1:0]  total_read;
  } fifo_beat_t;

  logic                        clk_i;
  logic                        rst_ni;
  logic                        cfg_we_i;
  logic [fcbf_pkg::CNT_W-1:0]  cfg_wdata_i;
  logic                        in_valid_i;
  logic                        in_stall_o;
  logic [fcbf_pkg::FUNC_W-1:0] func_i;
  logic [fcbf_pkg::BYTE_W-1:0] data_in_i;
  logic [fcbf_pkg::LEN_W-1:0]  length_i;
  logic                        out_valid_o;
  logic                        out_stall_i;
  logic [fcbf_pkg::BYTE_W-1:0] data_out_o;
  logic                        last_o;
  logic [fcbf_pkg::STAT_W-1:0] status_o;
  logic [fcbf_pkg::CNT_W-1:0]  occupancy_o;
  logic [fcbf_pkg::CNT_W-1:0]  space_left_o;
  logic                        ended_o;
  logic                        at_eof_o;
  logic [fcbf_pkg::TOT_W-1:0]  total_written_o;
  logic [fcbf_pkg::TOT_W-1:0]  total_read_o;

  // Shadow copy of the FIFO state.
  logic [fcbf_pkg::BYTE_W-1:0] shadow_mem [FIFO_DEPTH];
  logic [9:0]                  shadow_head;
  logic [fcbf_pkg::CNT_W-1:0]  shadow_fill;
  logic [fcbf_pkg::TOT_W-1:0]  shadow_wtot;
  logic [fcbf_pkg::TOT_W-1:0]  shadow_rtot;
  logic                        shadow_ended;
  logic [fcbf_pkg::CNT_W-1:0]  shadow_cap;

  // Expected results, kept in a ring with running write and read counts.
  fifo_beat_t exp_beats [EXP_DEPTH];
  int exp_wr_cnt = 0;
  int exp_rd_cnt = 0;

  int errors        = 0;
  int items_sent    = 0;
  int beats_checked = 0;
  int burst_left    = 4;
  int hold_request  = 0;
  int hold_left     = 0;
  int pattern_age   = 0;
  logic [7:0] stall_mask  = 8'h00;
  logic [2:0] stall_phase = 3'd0;

  flow_controlled_byte_fifo_core #(
    .DEPTH  (FIFO_DEPTH),
    .MAX_LEN(FIFO_MAX_LEN)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .func_i         (func_i),
    .data_in_i      (data_in_i),
    .length_i       (length_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .data_out_o     (data_out_o),
    .last_o         (last_o),
    .status_o       (status_o),
    .occupancy_o    (occupancy_o),
    .space_left_o   (space_left_o),
    .ended_o        (ended_o),
    .at_eof_o       (at_eof_o),
    .total_written_o(total_written_o),
    .total_read_o   (total_read_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #24_000_000;
    $display("flow_controlled_byte_fifo_core test failed");
    $finish;
  end

  task automatic push_beat(input logic [fcbf_pkg::BYTE_W-1:0] d, input logic lst,
                           input logic [fcbf_pkg::STAT_W-1:0] st);
    fifo_beat_t b;
    logic [fcbf_pkg::CNT_W-1:0] cap_eff;
    cap_eff = (shadow_cap > fcbf_pkg::CNT_W'(FIFO_DEPTH)) ? fcbf_pkg::CNT_W'(FIFO_DEPTH)
                                                          : shadow_cap;
    b.data          = d;
    b.last          = lst;
    b.status        = st;
    b.occupancy     = shadow_fill;
    b.space_left    = (cap_eff > shadow_fill) ? cap_eff - shadow_fill : '0;
    b.ended         = shadow_ended;
    b.at_eof        = shadow_ended && (shadow_fill == '0);
    b.total_written = shadow_wtot;
    b.total_read    = shadow_rtot;
    exp_beats[exp_wr_cnt % EXP_DEPTH] = b;
    exp_wr_cnt++;
  endtask

  task automatic apply_fifo_op(input logic [fcbf_pkg::FUNC_W-1:0] f,
                               input logic [fcbf_pkg::BYTE_W-1:0] d,
                               input logic [fcbf_pkg::LEN_W-1:0] n);
    logic [fcbf_pkg::BYTE_W-1:0] grabbed [FIFO_MAX_LEN];
    logic [fcbf_pkg::CNT_W-1:0]  cap_eff;
    logic [9:0]                  idx;
    logic [fcbf_pkg::TOT_W:0]    sum;
    cap_eff = (shadow_cap > fcbf_pkg::CNT_W'(FIFO_DEPTH)) ? fcbf_pkg::CNT_W'(FIFO_DEPTH)
                                                          : shadow_cap;
    if (f == fcbf_pkg::FUNC_WRITE) begin
      if (shadow_fill >= cap_eff) begin
        push_beat('0, 1'b1, fcbf_pkg::STATUS_FULL);
      end else begin
        idx = shadow_head + shadow_fill[9:0];
        shadow_mem[idx] = d;
        shadow_fill = shadow_fill + fcbf_pkg::CNT_W'(1);
        if (shadow_wtot != fcbf_pkg::TOT_MAX) shadow_wtot = shadow_wtot + fcbf_pkg::TOT_W'(1);
        push_beat('0, 1'b1, fcbf_pkg::STATUS_OK);
      end
    end else if (f == fcbf_pkg::FUNC_END) begin
      shadow_ended = 1'b1;
      push_beat('0, 1'b1, fcbf_pkg::STATUS_OK);
    end else if (f > fcbf_pkg::FUNC_END) begin
      push_beat('0, 1'b1, fcbf_pkg::STATUS_OK);
    end else if (fcbf_pkg::CNT_W'(n) > shadow_fill || int'(n) > FIFO_MAX_LEN) begin
      push_beat('0, 1'b1, fcbf_pkg::STATUS_RANGE);
    end else begin
      for (int i = 0; i < int'(n); i++) begin
        idx = shadow_head + 10'(i);
        grabbed[i] = shadow_mem[idx];
      end
      if (f != fcbf_pkg::FUNC_PEEK) begin
        shadow_head = shadow_head + 10'(n);
        shadow_fill = shadow_fill - fcbf_pkg::CNT_W'(n);
        sum = {1'b0, shadow_rtot} + (fcbf_pkg::TOT_W + 1)'(n);
        shadow_rtot = sum[fcbf_pkg::TOT_W] ? fcbf_pkg::TOT_MAX : sum[fcbf_pkg::TOT_W-1:0];
      end
      if (f == fcbf_pkg::FUNC_POP || n == '0) begin
        push_beat('0, 1'b1, fcbf_pkg::STATUS_OK);
      end else begin
        for (int i = 0; i < int'(n); i++) begin
          push_beat(grabbed[i], i == int'(n) - 1, fcbf_pkg::STATUS_OK);
        end
      end
    end
  endtask

  task automatic send_op(input logic [fcbf_pkg::FUNC_W-1:0] f,
                         input logic [fcbf_pkg::BYTE_W-1:0] d,
                         input logic [fcbf_pkg::LEN_W-1:0] n);
    int gap;
    @(negedge clk_i);
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      gap = $urandom_range(1, 6);
      repeat (gap) @(negedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
    end
    in_valid_i <= 1'b1;
    func_i     <= f;
    data_in_i  <= d;
    length_i   <= n;
    do @(posedge clk_i); while (in_stall_o);
    apply_fifo_op(f, d, n);
    burst_left--;
    items_sent++;
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (exp_wr_cnt != exp_rd_cnt) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic set_capacity(input logic [fcbf_pkg::CNT_W-1:0] v);
    wait_idle();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    shadow_cap = v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [fcbf_pkg::LEN_W-1:0] pick_len();
    int lim;
    lim = (int'(shadow_fill) > FIFO_MAX_LEN) ? FIFO_MAX_LEN : int'(shadow_fill);
    if ($urandom_range(0, 3) == 0) return fcbf_pkg::LEN_W'(lim);
    return fcbf_pkg::LEN_W'($urandom_range(0, lim));
  endfunction

  task automatic check_field(input string name, input logic [fcbf_pkg::TOT_W-1:0] exp_v,
                             input logic [fcbf_pkg::TOT_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk_i) begin : result_checker
    fifo_beat_t b;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (exp_wr_cnt == exp_rd_cnt) begin
        $error("result transfer with no expected result pending");
        errors++;
      end else begin
        b = exp_beats[exp_rd_cnt % EXP_DEPTH];
        exp_rd_cnt++;
        check_field("data_out", fcbf_pkg::TOT_W'(b.data), fcbf_pkg::TOT_W'(data_out_o));
        check_field("last", fcbf_pkg::TOT_W'(b.last), fcbf_pkg::TOT_W'(last_o));
        check_field("status", fcbf_pkg::TOT_W'(b.status), fcbf_pkg::TOT_W'(status_o));
        check_field("occupancy", fcbf_pkg::TOT_W'(b.occupancy),
                    fcbf_pkg::TOT_W'(occupancy_o));
        check_field("space_left", fcbf_pkg::TOT_W'(b.space_left),
                    fcbf_pkg::TOT_W'(space_left_o));
        check_field("ended", fcbf_pkg::TOT_W'(b.ended), fcbf_pkg::TOT_W'(ended_o));
        check_field("at_eof", fcbf_pkg::TOT_W'(b.at_eof), fcbf_pkg::TOT_W'(at_eof_o));
        check_field("total_written", b.total_written, total_written_o);
        check_field("total_read", b.total_read, total_read_o);
        beats_checked++;
      end
    end
  end

  // The output side stalls on a rotating mask that is replaced whenever its age counter runs out,
  // or holds off completely for as long as a test requests.
  always @(negedge clk_i) begin
    if (hold_request > 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else begin
      if (pattern_age == 0) begin
        pattern_age = 64;
        stall_mask  = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom);
      end
      out_stall_i <= stall_mask[stall_phase];
      stall_phase = stall_phase + 3'd1;
      pattern_age--;
    end
  end

  task automatic test_directed_ops();
    send_op(fcbf_pkg::FUNC_PEEK, 8'h00, 7'd1);
    send_op(fcbf_pkg::FUNC_READ, 8'hFF, 7'd0);
    send_op(fcbf_pkg::FUNC_POP, 8'h00, 7'd0);
    send_op(fcbf_pkg::FUNC_WRITE, 8'h00, 7'd0);
    send_op(fcbf_pkg::FUNC_WRITE, 8'hFF, 7'd127);
    send_op(fcbf_pkg::FUNC_WRITE, 8'hA5, 7'd0);
    send_op(fcbf_pkg::FUNC_PEEK, 8'h00, 7'd3);
    send_op(fcbf_pkg::FUNC_READ, 8'h00, 7'd1);
    send_op(fcbf_pkg::FUNC_POP, 8'h00, 7'd1);
    send_op(fcbf_pkg::FUNC_READ, 8'h00, 7'd1);
    for (int k = 0; k < 3; k++) begin
      send_op(FUNC_SPARE_FIRST + fcbf_pkg::FUNC_W'(k), 8'hFF, 7'd127);
    end
    send_op(fcbf_pkg::FUNC_POP, 8'h00, 7'd127);
    send_op(fcbf_pkg::FUNC_PEEK, 8'h00, 7'd64);
    send_op(fcbf_pkg::FUNC_END, 8'h00, 7'd0);
    send_op(fcbf_pkg::FUNC_WRITE, 8'h5A, 7'd0);
    send_op(fcbf_pkg::FUNC_READ, 8'h00, 7'd1);
  endtask

  task automatic test_capacity_edges();
    set_capacity(11'd0);
    send_op(fcbf_pkg::FUNC_WRITE, 8'h3C, 7'd0);
    send_op(fcbf_pkg::FUNC_POP, 8'h00, 7'd0);
    set_capacity(11'd1);
    send_op(fcbf_pkg::FUNC_WRITE, 8'hC3, 7'd0);
    send_op(fcbf_pkg::FUNC_WRITE, 8'h99, 7'd0);
    send_op(fcbf_pkg::FUNC_READ, 8'h00, 7'd1);
  endtask

  // Capacity above the memory depth and a capacity lowered below the current occupancy.
  task automatic test_capacity_above_depth();
    set_capacity(fcbf_pkg::CNT_MAX);
    for (int i = 0; i < 60; i++) send_op(fcbf_pkg::FUNC_WRITE, 8'($urandom), 7'd0);
    set_capacity(11'd16);
    send_op(fcbf_pkg::FUNC_WRITE, 8'h22, 7'd0);
    send_op(fcbf_pkg::FUNC_READ, 8'h00, 7'd40);
    send_op(fcbf_pkg::FUNC_WRITE, 8'h33, 7'd0);
    send_op(fcbf_pkg::FUNC_POP, 8'h00, 7'd10);
    send_op(fcbf_pkg::FUNC_WRITE, 8'h44, 7'd0);
    send_op(fcbf_pkg::FUNC_READ, 8'h00, 7'd5);
    set_capacity(fcbf_pkg::CAP_RESET);
  endtask

  task automatic test_backpressure();
    wait_idle();
    hold_request = 400;
    for (int i = 0; i < 40; i++) send_op(fcbf_pkg::FUNC_WRITE, 8'($urandom), 7'd0);
    send_op(fcbf_pkg::FUNC_PEEK, 8'h00, 7'd40);
    send_op(fcbf_pkg::FUNC_READ, 8'h00, 7'd40);
  endtask

  task automatic test_random_traffic();
    logic [fcbf_pkg::CNT_W-1:0] caps [5];
    int r;
    caps[0] = fcbf_pkg::CNT_W'($urandom_range(1, 40));
    caps[1] = fcbf_pkg::CAP_RESET;
    caps[2] = fcbf_pkg::CNT_MAX;
    caps[3] = fcbf_pkg::CNT_W'($urandom_range(0, 2047));
    caps[4] = fcbf_pkg::CNT_W'($urandom_range(1, 8));
    foreach (caps[p]) begin
      set_capacity(caps[p]);
      for (int i = 0; i < RANDOM_ITEMS / 5; i++) begin
        r = $urandom_range(0, 99);
        if (r < 45) begin
          send_op(fcbf_pkg::FUNC_WRITE, 8'($urandom), fcbf_pkg::LEN_W'($urandom));
        end else if (r < 55) begin
          send_op(fcbf_pkg::FUNC_PEEK, 8'($urandom), pick_len());
        end else if (r < 68) begin
          send_op(fcbf_pkg::FUNC_READ, 8'($urandom), pick_len());
        end else if (r < 80) begin
          send_op(fcbf_pkg::FUNC_POP, 8'($urandom), pick_len());
        end else if (r < 84) begin
          send_op(fcbf_pkg::FUNC_END, 8'($urandom), fcbf_pkg::LEN_W'($urandom));
        end else if (r < 90) begin
          send_op(fcbf_pkg::FUNC_W'($urandom_range(5, 7)), 8'($urandom),
                  fcbf_pkg::LEN_W'($urandom));
        end else begin
          send_op(fcbf_pkg::FUNC_W'($urandom_range(1, 3)), 8'($urandom),
                  fcbf_pkg::LEN_W'($urandom));
        end
      end
    end
  endtask

  initial begin
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_wdata_i  = '0;
    in_valid_i   = 1'b0;
    func_i       = fcbf_pkg::FUNC_WRITE;
    data_in_i    = '0;
    length_i     = '0;
    out_stall_i  = 1'b0;
    shadow_head  = '0;
    shadow_fill  = '0;
    shadow_wtot  = '0;
    shadow_rtot  = '0;
    shadow_ended = 1'b0;
    shadow_cap   = fcbf_pkg::CAP_RESET;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed_ops();
    test_capacity_edges();
    test_capacity_above_depth();
    test_backpressure();
    test_random_traffic();
    wait_idle();
    repeat (40) @(posedge clk_i);

    $display("Sent %0d operations and checked %0d result transfers.", items_sent, beats_checked);
    $display("Covered capacities from zero to above depth, a shrunk capacity and a long hold.");
    if (errors == 0) begin
      $display("flow_controlled_byte_fifo_core test passed");
    end else begin
      $display("flow_controlled_byte_fifo_core test failed");
    end
    $finish;
  end

endmodule
